/* hdl/lgu_pkg.sv */
// Shared types and constants for the loss and gradient unit.
package lgu_pkg;
  localparam int FracBits = 16;
  localparam int InWidth = FracBits + 1;
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  typedef struct packed {
    logic [InWidth-1:0] output_value;
    logic [InWidth-1:0] expected_value;
    logic last;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] gradient;
    logic [31:0] cost_sum;
    logic end_of_vector;
    logic invalid;
  } out_word_t;
endpackage

/* hdl/lgu_seq.sv */
// Shared datapath sequencer: one subtract-compare or one multiply per cycle.
module lgu_seq import lgu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        mode,
  input  in_word_t    word,
  output logic        done,
  output logic [31:0] grad_mag,
  output logic        grad_neg,
  output logic [33:0] cost_add,
  output logic        bad,
  output logic        div_zero
);
  localparam int FRAC_BITS = FracBits;
  localparam int OneW = FRAC_BITS + 2;
  localparam logic [OneW-1:0] OneFx = OneW'(1) << FRAC_BITS;
  localparam int QW = 2 * FRAC_BITS + 2;
  localparam int CW = $clog2(QW + 1) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_LN   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [CW-1:0] cnt;
  logic [OneW-1:0] mag;
  logic neg;
  logic [2*OneW-1:0] den;
  logic [2*OneW+1:0] rem;
  logic [QW-1:0] num;
  logic [QW-1:0] q;
  logic [OneW:0] y;
  logic [5:0] n;
  logic [FRAC_BITS-1:0] frac;
  logic [31:0] nl2;
  logic [63:0] prod;
  logic [2*OneW+1:0] sq;
  logic [OneW-1:0] oc, ec, mc, arg;
  logic [2*OneW+1:0] rs;

  // the dividend is mag << 2*FRAC_BITS; its bits above num start out in rem
  always_comb begin
    oc = (word.output_value > InWidth'(OneFx)) ? OneFx : OneW'(word.output_value);
    ec = (word.expected_value > InWidth'(OneFx)) ? OneFx : OneW'(word.expected_value);
    mc = (oc >= ec) ? oc - ec : ec - oc;
    sq = (2*OneW+2)'(y) * (2*OneW+2)'(y);
    rs = {rem[2*OneW:0], num[QW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          neg <= oc < ec;
          mag <= mc;
          den <= (2*OneW)'(oc) * (2*OneW)'(OneFx - oc);
          num <= QW'(mc) << (2 * FRAC_BITS);
          rem <= (2*OneW+2)'(mc >> 2);
          q <= '0;
          cnt <= '0;
          arg <= (ec != 0) ? oc : OneFx - oc;
          bad <= 1'b0;
          state <= mode ? S_LN : S_DIV;
        end
        S_DIV: begin
          if (den == 0) begin
            state <= S_NORM;
            y <= (OneW+1)'(arg);
            n <= '0;
          end else begin
            num <= num << 1;
            if (rs >= (2*OneW+2)'(den)) begin
              rem <= rs - (2*OneW+2)'(den);
              q <= {q[QW-2:0], 1'b1};
            end else begin
              rem <= rs;
              q <= {q[QW-2:0], 1'b0};
            end
            cnt <= cnt + 1'b1;
            if (cnt == CW'(QW - 1)) begin
              state <= S_NORM;
              y <= (OneW+1)'(arg);
              n <= '0;
            end
          end
        end
        S_NORM: begin
          cnt <= '0;
          frac <= '0;
          if (y == 0) begin
            bad <= 1'b1;
            state <= S_DONE;
          end else if (y < (OneW+1)'(OneFx)) begin
            y <= y << 1;
            n <= n + 1'b1;
          end else begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (sq[FRAC_BITS +: OneW+2] >= (OneW+2)'(2 * OneFx)) begin
            y <= (OneW+1)'(sq[FRAC_BITS+1 +: OneW+1]);
            frac <= {frac[FRAC_BITS-2:0], 1'b1};
          end else begin
            y <= (OneW+1)'(sq[FRAC_BITS +: OneW+1]);
            frac <= {frac[FRAC_BITS-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(FRAC_BITS - 1)) begin
            state <= S_LN;
          end
        end
        S_LN: begin
          nl2 <= (32'(n) << FRAC_BITS) - 32'(frac);
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    prod = 64'(nl2) * 64'(Ln2Q32);
    grad_neg = neg;
    div_zero = (den == 0);
    if (mode) begin
      grad_mag = 32'(mag);
      cost_add = 34'((2*OneW)'(mag) * (2*OneW)'(mag) >> (FRAC_BITS + 1));
    end else begin
      if (den == 0) begin
        grad_mag = (mag == 0) ? 32'd0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
      end else if (neg) begin
        grad_mag = (q > QW'(33'h8000_0000)) ? 32'h8000_0000 : 32'(q);
      end else begin
        grad_mag = (q > QW'(33'h7FFF_FFFF)) ? 32'h7FFF_FFFF : 32'(q);
      end
      // log of zero: large enough to saturate any sum, small enough not to wrap
      cost_add = bad ? 34'h1_FFFF_FFFF : 34'(prod[63:32]);
    end
  end
endmodule

/* hdl/loss_and_gradient_unit.sv */
// Top level of the loss and gradient unit.
// In cross-entropy mode a word goes from acceptance to its result word through a 2*FRAC_BITS+2
// step shift-subtract divider, up to FRAC_BITS left shifts that normalize the log argument,
// one squaring per log bit, then the ln 2 scaling. When the output is 0 or one the divider
// steps are skipped, and a log of zero also skips the squaring and the scaling. Quadratic mode
// skips the divider, normalize and squaring steps. in_ready is low from acceptance until the
// result enters the output register, so the next word can be accepted in the cycle after;
// a result waiting there does not hold off the next word.
module loss_and_gradient_unit import lgu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);
  logic mode, busy, done, bad, div_zero, grad_neg, last, inv, fin, move, v;
  logic [31:0] grad_mag, acc, a;
  logic [33:0] cost_add, sum;

  assign in_ready = !busy;
  assign sum = 34'(acc) + cost_add;
  assign move = (done || fin) && (!out_valid || out_ready);
  assign a = sum[33:32] != 0 ? 32'hFFFF_FFFF : sum[31:0];
  assign v = inv || (!mode && (bad || div_zero));

  lgu_seq u_seq (
    .clk, .rst, .start(in_valid && in_ready), .mode, .word(in_data), .done,
    .grad_mag, .grad_neg, .cost_add, .bad, .div_zero
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      busy <= 1'b0;
      fin <= 1'b0;
      out_valid <= 1'b0;
      acc <= '0;
      inv <= 1'b0;
    end else begin
      if (cfg_we) mode <= cfg_data;
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        last <= in_data.last;
      end else if (move) begin
        busy <= 1'b0;
      end
      if (move) begin
        fin <= 1'b0;
      end else if (done) begin
        fin <= 1'b1;
      end
      if (move) begin
        out_valid <= 1'b1;
        out_data.gradient <= grad_neg ? 32'd0 - grad_mag : grad_mag;
        out_data.cost_sum <= last ? a : 32'd0;
        out_data.end_of_vector <= last;
        out_data.invalid <= v;
        acc <= last ? 32'd0 : a;
        inv <= last ? 1'b0 : v;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("accepted while busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without work");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    done |-> !fin) else $error("pending result overrun");
`endif
endmodule

/* tb/loss_and_gradient_unit_test.sv */
// Self-checking testbench for the loss and gradient unit with a scoreboard class.
module loss_and_gradient_unit_test import lgu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frac = FracBits;
  localparam logic [63:0] One = 64'd1 << Frac;
  localparam logic ModeXent = 1'b0;
  localparam logic ModeQuad = 1'b1;
  localparam int DrainCycles = 100;
  localparam int StallLimit = 20000;

  class loss_scoreboard;
    out_word_t expected_words[$];
    logic loss_mode;
    logic [31:0] cost_acc;
    logic invalid_seen;
    int errors;

    function new();
      loss_mode = ModeXent;
      cost_acc = '0;
      invalid_seen = 1'b0;
      errors = 0;
    endfunction

    function logic [63:0] neg_ln(logic [63:0] x);
      logic [63:0] y, n, frac, nl2;
      y = x;
      n = 0;
      frac = 0;
      while (y < One) begin
        y = y << 1;
        n++;
      end
      for (int i = 0; i < Frac; i++) begin
        y = (y * y) >> Frac;
        frac = frac << 1;
        if (y >= 2 * One) begin
          y = y >> 1;
          frac[0] = 1'b1;
        end
      end
      nl2 = n * One - frac;
      return (nl2 * 64'(Ln2Q32)) >> 32;
    endfunction

    function logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] den);
      logic [63:0] a, q, r;
      a = num << Frac;
      q = a / den;
      r = a % den;
      for (int i = 0; i < Frac; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function void add_cost(logic [63:0] v);
      logic [63:0] s;
      s = 64'(cost_acc) + v;
      cost_acc = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void note(in_word_t w);
      logic [63:0] o, e, mag, den, arg, q, g;
      logic neg;
      out_word_t r;
      o = 64'(w.output_value);
      e = 64'(w.expected_value);
      if (o > One) o = One;
      if (e > One) e = One;
      neg = (o < e);
      mag = neg ? e - o : o - e;
      if (loss_mode == ModeXent) begin
        den = o * (One - o);
        arg = (e != 0) ? o : One - o;
        if (den == 0) begin
          invalid_seen = 1'b1;
          q = (mag == 0) ? 64'd0 : (neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
        end else begin
          q = scaled_quotient(mag, den);
          if (neg && q > 64'h8000_0000) q = 64'h8000_0000;
          if (!neg && q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        end
        mag = q;
        if (arg == 0) begin
          invalid_seen = 1'b1;
          cost_acc = 32'hFFFF_FFFF;
        end else begin
          add_cost(neg_ln(arg));
        end
      end else begin
        add_cost((mag * mag) >> (Frac + 1));
      end
      g = neg ? 64'd0 - mag : mag;
      r.gradient = g[31:0];
      r.cost_sum = w.last ? cost_acc : 32'd0;
      r.end_of_vector = w.last;
      r.invalid = invalid_seen;
      expected_words.push_back(r);
      if (w.last) begin
        cost_acc = '0;
        invalid_seen = 1'b0;
      end
    endfunction

    function void check(out_word_t got);
      out_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.gradient !== exp_w.gradient) begin
        $error("gradient: expected %h, got %h", exp_w.gradient, got.gradient);
        errors++;
      end
      if (got.cost_sum !== exp_w.cost_sum) begin
        $error("cost_sum: expected %h, got %h", exp_w.cost_sum, got.cost_sum);
        errors++;
      end
      if (got.end_of_vector !== exp_w.end_of_vector) begin
        $error("end_of_vector: expected %b, got %b", exp_w.end_of_vector, got.end_of_vector);
        errors++;
      end
      if (got.invalid !== exp_w.invalid) begin
        $error("invalid: expected %b, got %b", exp_w.invalid, got.invalid);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  loss_scoreboard sb = new();
  bit idling_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  loss_and_gradient_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check(out_data);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(in_word_t w);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note(w);
  endtask

  task automatic drain_and_set_mode(logic m);
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.loss_mode = m;
  endtask

  function logic [16:0] rand_field();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return $urandom_range(0, 1) ? 17'h10000 : 17'h0;
      1: return 17'($urandom_range(0, 17'h1FFFF));
      2: return $urandom_range(0, 1) ? 17'($urandom_range(1, 8))
                                     : 17'($urandom_range(65528, 65535));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic run_directed();
    in_word_t w;
    logic [16:0] os[11] = '{17'h0, 17'h0, 17'h10000, 17'h10000, 17'h1FFFF, 17'h8000,
                            17'h1, 17'hFFFF, 17'h1FFFF, 17'h0FFFF, 17'h4E20};
    logic [16:0] es[11] = '{17'h0, 17'h10000, 17'h0, 17'h10000, 17'h1FFFF, 17'h8000,
                            17'h10000, 17'h0, 17'h0, 17'h1FFFF, 17'h10000};
    logic ls[11] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    for (int i = 0; i < 11; i++) begin
      w.output_value = os[i];
      w.expected_value = es[i];
      w.last = ls[i];
      send_word(w);
    end
  endtask

  task automatic run_random(int count);
    in_word_t w;
    for (int i = 0; i < count; i++) begin
      w.output_value = rand_field();
      w.expected_value = ($urandom_range(0, 9) == 0) ? w.output_value : rand_field();
      w.last = ($urandom_range(0, 4) == 0);
      send_word(w);
    end
  endtask

  initial begin
    logic modes[6] = '{ModeQuad, ModeXent, ModeQuad, ModeXent, ModeXent, ModeQuad};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drain_and_set_mode(ModeXent);
    run_directed();
    drain_and_set_mode(ModeQuad);
    run_directed();
    for (int p = 0; p < 6; p++) begin
      drain_and_set_mode(modes[p]);
      idling_on = (p != 3);
      run_random(188);
    end
    idling_on = 1'b1;
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/lgu_pkg.sv
hdl/lgu_seq.sv
hdl/loss_and_gradient_unit.sv
tb/loss_and_gradient_unit_test.sv
